// ----- src/swrc_pkg.sv -----
// Shared types and constants of the sliding window range check block.
`default_nettype none

package swrc_pkg;

  localparam int unsigned SAMPLE_W     = 20;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned THR_W        = 20;
  localparam int unsigned POS_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;

  // Result kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_NONE  = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] window_start;
  } out_t;

endpackage

`default_nettype wire

// ----- src/sliding_window_range_check_core.sv -----
// Top level of the sliding window range check: cell chain, select tree, result stage.
//
// Sliding window range check. Each request carries one unsigned sample; once the
// current stream holds at least window_len samples, every sample closes a window,
// and when max minus min of that window is at most threshold the block returns
// the 1-based start position of the window. On the sample flagged last, if no
// window of the stream matched, a none-found result (window_start 0) comes out
// instead and the stream count restarts. A window_len of 0 acts as 1 and one
// above WINDOW_MAX acts as WINDOW_MAX. Rate: one sample per clock cycle while
// the output is taken and no configuration write waits. The select tree, one
// pipeline stage per tree level, picks the chain cell that spans exactly the
// effective window length and feeds the result register. The whole pipeline
// holds while a result waits in the output register. There is no clearing
// pass after reset: the chain needs none, because a cell is only looked at
// once the stream has filled it. Configuration writes are taken only while no
// sample is in the pipeline and apply from the next sample on; a pending write
// holds off new sample requests until the pipeline has drained.
`default_nettype none

module sliding_window_range_check_core
  import swrc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // sample requests
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  // results
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(WINDOW_MAX);
  localparam int unsigned L     = 2**IDX_W;
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW    = SAMPLE_BITS;
  localparam int unsigned DW    = 2 * SW;
  localparam int unsigned CMP_W = (SW > THR_W) ? SW : THR_W;

  // Item data that travels alongside the select tree.
  typedef struct packed {
    logic             last;
    logic             check;
    logic [POS_W-1:0] pos;
  } side_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] len_q;
  logic [THR_W-1:0] thr_q;
  logic [IDX_W:0]   side_valid_q;
  logic             pipe_idle;

  // Hold a write until no sample is in flight: the tree and the result stage read
  // the registers late.
  assign pipe_idle   = !(|side_valid_q);
  assign cfg_ready_o = pipe_idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WINDOW_LEN: len_q <= cfg_data_i[LEN_W-1:0];
        CFG_THRESHOLD:  thr_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length and the chain cell that spans it.
  logic [31:0]      len32;
  logic [31:0]      m32;
  logic [CNT_W-1:0] m_eff;
  logic [IDX_W-1:0] tap;

  always_comb begin
    len32 = 32'(len_q);
    if (len32 == 32'd0) begin
      m32 = 32'd1;
    end else if (len32 > 32'(WINDOW_MAX)) begin
      m32 = 32'(WINDOW_MAX);
    end else begin
      m32 = len32;
    end
    m_eff = CNT_W'(m32);
    tap   = IDX_W'(m32 - 32'd1);
  end

  // ---------------------------------------------------------------------------
  // Handshake: the whole pipeline advances unless a result is stuck at the output
  // ---------------------------------------------------------------------------
  logic adv;
  logic acc;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  // Hold off samples while a configuration write waits, so the pipeline drains.
  assign in_ready_o = adv && !cfg_valid_i;
  assign acc        = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Stream bookkeeping at the front
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [CNT_W-1:0] fill_q, fill_d, fill_new;
  side_t            front;

  always_comb begin
    cnt_new  = cnt_q + POS_W'(1);
    fill_new = (fill_q == CNT_W'(WINDOW_MAX)) ? fill_q : fill_q + CNT_W'(1);
    front.last  = in_data_i.last_sample;
    // Full window is judged on the fill level, so a wrapped count keeps checking.
    front.check = (fill_new >= m_eff);
    front.pos   = cnt_new - m32 + POS_W'(1);
    if (in_data_i.last_sample) begin
      cnt_d  = '0;
      fill_d = '0;
    end else begin
      cnt_d  = cnt_new;
      fill_d = fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fill_q <= '0;
    end else if (acc) begin
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Prefix chain: cell k holds min and max of the newest k+1 samples
  // ---------------------------------------------------------------------------
  logic [SW-1:0] s_w;
  logic [SW-1:0] pmin [WINDOW_MAX];
  logic [SW-1:0] pmax [WINDOW_MAX];
  logic [DW-1:0] leaves [L];

  assign s_w = SW'(in_data_i.sample);

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    logic [SW-1:0] nb_min;
    logic [SW-1:0] nb_max;
    // The head cell sees only the new sample.
    if (k == 0) begin : g_head
      assign nb_min = s_w;
      assign nb_max = s_w;
    end else begin : g_body
      assign nb_min = pmin[k-1];
      assign nb_max = pmax[k-1];
    end
    swrc_cell #(
      .SW(SW)
    ) u_cell (
      .clk_i      (clk_i),
      .en_i       (acc),
      .sample_i   (s_w),
      .prev_min_i (nb_min),
      .prev_max_i (nb_max),
      .min_o      (pmin[k]),
      .max_o      (pmax[k])
    );
  end

  for (genvar k = 0; k < L; k++) begin : g_leaf
    if (k < WINDOW_MAX) begin : g_used
      assign leaves[k] = {pmax[k], pmin[k]};
    end else begin : g_pad
      assign leaves[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Select tree and matching side pipeline
  // ---------------------------------------------------------------------------
  logic [DW-1:0]  tree_data;
  side_t          side_q [IDX_W+1];

  swrc_tap_tree #(
    .IDX_W(IDX_W),
    .DW   (DW)
  ) u_tap_tree (
    .clk_i    (clk_i),
    .en_i     (adv),
    .sel_i    (tap),
    .leaves_i (leaves),
    .data_o   (tree_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_valid_q <= '0;
    end else if (adv) begin
      side_valid_q <= {side_valid_q[IDX_W-1:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= front;
      for (int i = 1; i <= IDX_W; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: range compare, match flag, output register
  // ---------------------------------------------------------------------------
  logic          any_match_q, any_match_d;
  logic [SW-1:0] win_hi, win_lo, win_rng;
  logic          hit;
  logic          emit;
  out_t          res_d;
  out_t          out_q;
  side_t         tail;
  logic          tail_valid;

  assign tail       = side_q[IDX_W];
  assign tail_valid = side_valid_q[IDX_W];

  always_comb begin
    win_hi  = tree_data[DW-1:SW];
    win_lo  = tree_data[SW-1:0];
    win_rng = win_hi - win_lo;
    hit     = tail.check && (CMP_W'(win_rng) <= CMP_W'(thr_q));
    emit    = 1'b0;
    res_d   = out_q;
    any_match_d = any_match_q;
    if (tail_valid) begin
      if (hit) begin
        emit               = 1'b1;
        res_d.result_kind  = KIND_MATCH;
        res_d.window_start = tail.pos;
        any_match_d        = 1'b1;
      end
      if (tail.last) begin
        // Report none-found only when the whole stream, this sample included, missed.
        if (!(any_match_q || hit)) begin
          emit               = 1'b1;
          res_d.result_kind  = KIND_NONE;
          res_d.window_start = '0;
        end
        any_match_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      any_match_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
      any_match_q <= any_match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_clears_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.last_sample |=> (cnt_q == '0) && (fill_q == '0))
    else $error("stream count not cleared after last sample");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_data_i.last_sample |=> (fill_q != '0))
    else $error("fill level empty after a non-last sample");

  a_last_clears_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && tail_valid && tail.last |=> !any_match_q)
    else $error("match flag survives end of stream");

  a_none_has_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == KIND_NONE) |-> (out_data_o.window_start == '0))
    else $error("none-found result with nonzero start");

  a_result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tail_valid))
    else $error("result appeared without an item at the pipeline tail");

endmodule

`default_nettype wire

// ----- src/swrc_cell.sv -----
// One cell of the prefix chain: min and max of the newest samples up to its depth.
`default_nettype none

module swrc_cell #(
  parameter int unsigned SW = 20
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [SW-1:0] sample_i,
  input  wire logic [SW-1:0] prev_min_i,
  input  wire logic [SW-1:0] prev_max_i,
  output logic      [SW-1:0] min_o,
  output logic      [SW-1:0] max_o
);

  logic [SW-1:0] min_q, min_d;
  logic [SW-1:0] max_q, max_d;

  // Fold the new sample into the neighbor's span, which is one sample shorter.
  assign min_d = (sample_i < prev_min_i) ? sample_i : prev_min_i;
  assign max_d = (sample_i > prev_max_i) ? sample_i : prev_max_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

// ----- src/swrc_tap_tree.sv -----
// Pipelined select tree that picks one chain cell, one tree level per stage.
`default_nettype none

module swrc_tap_tree #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned DW    = 40
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [IDX_W-1:0] sel_i,
  input  wire logic [DW-1:0]    leaves_i [2**IDX_W],
  output logic      [DW-1:0]    data_o
);

  localparam int unsigned L = 2**IDX_W;

  // Heap layout: node i has children 2i and 2i+1, leaves sit at L..2L-1.
  logic [DW-1:0] node_q [1:L-1];
  logic [DW-1:0] all_w  [1:2*L-1];

  always_comb begin
    for (int i = 1; i < L; i++) begin
      all_w[i] = node_q[i];
    end
    for (int i = 0; i < L; i++) begin
      all_w[L+i] = leaves_i[i];
    end
  end

  for (genvar i = 1; i < L; i++) begin : g_node
    // Nodes next to the leaves decide on the low index bit, the root on the high one.
    localparam int unsigned B = IDX_W - $clog2(i + 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        node_q[i] <= sel_i[B] ? all_w[2*i+1] : all_w[2*i];
      end
    end
  end

  assign data_o = node_q[1];

endmodule

`default_nettype wire
